// ===== rtl/core/dph_pkg.sv =====
// dph_pkg: shared types and constants for the DNA prefix histogram unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package dph_pkg;

    typedef enum logic [1:0] {
        REQ_CHAR  = 2'd0,
        REQ_START = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam int          IDX_BITS    = 16;      // widest prefix index (8 bases)
    localparam int          WORD_BITS   = 64;
    localparam int          TRIGGER_POS = 8;
    localparam int          RESP_DEPTH  = 4;
    localparam logic [5:0]  WL_RESET    = 6'd25;
    localparam logic [7:0]  POS_MAX     = 8'd255;

    typedef struct packed {
        logic                 hit;        // base landed on the trigger position
        logic [WORD_BITS-1:0] word_next;  // forward word after this transfer
    } front_t;

    typedef struct packed {
        logic                clear;
        logic                inc;
        logic [IDX_BITS-1:0] clr_addr;
    } bank_cmd_t;

    typedef struct packed {
        logic [31:0] total;
        logic        above;
        logic [31:0] count;
    } resp_t;

endpackage

`default_nettype wire

// ===== rtl/core/dph_front.sv =====
// dph_front: character decode, position counter, forward word and word_length register.
// Depends on dph_pkg.
`default_nettype none

module dph_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire dph_pkg::req_t req,
    input  wire logic [7:0]    ch,
    input  wire logic          cfg_wr,
    input  wire logic [5:0]    cfg_data,
    output dph_pkg::front_t    front
);
    import dph_pkg::*;

    logic [5:0]           wl_reg;
    logic [7:0]           pos_reg, pos_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [WORD_BITS-1:0] mask;
    logic [7:0]           pos_inc;
    logic [1:0]           code;
    logic                 is_base, is_gap;
    logic                 hit;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (wl_reg >= 6'd32) || (7'(i) < {wl_reg, 1'b0});
        end
    end

    always_comb begin
        code    = 2'd0;
        is_base = 1'b0;
        is_gap  = 1'b0;
        case (ch)
            "0", "a", "A": begin is_base = 1'b1; code = 2'd0; end
            "2", "g", "G": begin is_base = 1'b1; code = 2'd1; end
            "3", "c", "C": begin is_base = 1'b1; code = 2'd2; end
            "1", "t", "T": begin is_base = 1'b1; code = 2'd3; end
            " ", 8'h0a:    begin is_gap = 1'b1; end
            default:       begin end
        endcase
    end

    assign pos_inc = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 8'd1;

    always_comb begin
        pos_next  = pos_reg;
        word_next = word_reg;
        hit       = 1'b0;
        if (accept) begin
            unique case (req)
                REQ_CHAR: begin
                    if (is_base) begin
                        pos_next  = pos_inc;
                        word_next = {word_reg[WORD_BITS-3:0], code} & mask;
                        hit       = (pos_inc == 8'(TRIGGER_POS));
                    end else if (is_gap) begin
                        pos_next = pos_inc;
                    end else begin
                        pos_next  = '0;
                        word_next = '0;
                    end
                end
                REQ_START: begin
                    pos_next  = '0;
                    word_next = '0;
                end
                REQ_QUERY, REQ_NONE: begin end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg   <= WL_RESET;
            pos_reg  <= '0;
            word_reg <= '0;
        end else begin
            if (cfg_wr) begin
                wl_reg <= cfg_data;
            end
            pos_reg  <= pos_next;
            word_reg <= word_next;
        end
    end

    assign front.hit       = hit;
    assign front.word_next = word_next;

endmodule

`default_nettype wire

// ===== rtl/core/dph_bank.sv =====
// dph_bank: counter memory of one prefix level with read-modify-write and forwarding.
// Depends on dph_pkg.
`default_nettype none

module dph_bank #(
    parameter int LEVEL        = 0,
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire dph_pkg::bank_cmd_t      cmd,
    input  wire logic [2*LEVEL+1:0]      rd_addr,
    output logic [COUNTER_BITS-1:0]      value
);
    import dph_pkg::*;

    localparam int AW    = 2 * LEVEL + 2;
    localparam int DEPTH = 1 << AW;

    logic [COUNTER_BITS-1:0] mem [DEPTH];
    logic [COUNTER_BITS-1:0] rd_data_reg;
    logic [AW-1:0]           s1_addr_reg;
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [COUNTER_BITS-1:0] fwd_data_reg;
    logic [COUNTER_BITS-1:0] inc_val;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [COUNTER_BITS-1:0] wr_data;

    // write of the previous cycle is not yet visible in rd_data_reg
    assign value   = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rd_data_reg;
    assign inc_val = (value == '1) ? value : value + 1'b1;

    assign wr_en   = cmd.clear || cmd.inc;
    assign wr_addr = cmd.clear ? cmd.clr_addr[AW-1:0] : s1_addr_reg;
    assign wr_data = cmd.clear ? '0 : inc_val;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg  <= rd_addr;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= inc_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= cmd.inc && !cmd.clear;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dph_resp_fifo.sv =====
// dph_resp_fifo: small result queue that decouples the pipeline from the output transfer.
// Depends on dph_pkg.
`default_nettype none

module dph_resp_fifo (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           push,
    input  wire dph_pkg::resp_t                 push_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output dph_pkg::resp_t                      m_data,
    output logic [$clog2(dph_pkg::RESP_DEPTH+1)-1:0] count
);
    import dph_pkg::*;

    localparam int PW = $clog2(RESP_DEPTH);
    localparam int CW = $clog2(RESP_DEPTH + 1);

    resp_t         entries [RESP_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = entries[rd_ptr_reg];
    assign count   = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn && push && !pop && count_reg == CW'(RESP_DEPTH)) begin
            $error("dph_resp_fifo: push into full queue");
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dna_prefix_histogram_unit.sv =====
// DNA prefix histogram unit: one transfer per cycle while s_tready is high; m_tvalid for a
// query result rises once the result, registered in the s1 stage, is written into the result
// queue. Every level has its own counter bank, so the eight increments of a counting event
// run in parallel through a read-modify-write path. s_tready drops while four query results
// are queued or in flight. After reset the banks are cleared one row per cycle, covering all
// 4^PREFIX_LEVELS rows (65536), with s_tready low; the configuration channel is ready throughout.
// Depends on dph_pkg, dph_front, dph_bank, dph_resp_fifo.
`default_nettype none

module dna_prefix_histogram_unit #(
    parameter int PREFIX_LEVELS = 8,
    parameter int COUNTER_BITS  = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // ch[7:0], query_level[10:8], query_index[26:11]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // count[31:0], above_threshold[32], total_reads[64:33]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data
);
    import dph_pkg::*;

    localparam int CW = $clog2(RESP_DEPTH + 1);
    localparam logic [IDX_BITS-1:0] CLR_LAST =
        IDX_BITS'((64'd1 << (2 * PREFIX_LEVELS)) - 64'd1);

    logic                    accept;
    req_t                    req;
    logic [7:0]              ch;
    logic [2:0]              query_level;
    logic [15:0]             query_index;
    front_t                  front;
    bank_cmd_t               cmd;

    logic                    clearing_reg;
    logic [IDX_BITS-1:0]     clr_addr_reg;
    logic [COUNTER_BITS-1:0] total_reg;
    logic                    s1_hit_reg, s1_query_reg;
    logic [2:0]              s1_level_reg;
    logic                    s1_lvl_ok_reg;
    logic [COUNTER_BITS-1:0] s1_total_reg;

    logic [COUNTER_BITS-1:0] bank_val [PREFIX_LEVELS];
    logic [COUNTER_BITS-1:0] sel_val, count_val, limit;
    resp_t                   resp, m_resp;
    logic [CW-1:0]           fifo_count;
    logic [CW:0]             occupancy;

    assign req         = req_t'(s_tuser);
    assign ch          = s_tdata[7:0];
    assign query_level = s_tdata[10:8];
    assign query_index = s_tdata[26:11];

    assign occupancy = {1'b0, fifo_count} + (CW + 1)'(s1_query_reg);
    assign s_tready  = !clearing_reg && (occupancy < (CW + 1)'(RESP_DEPTH));
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    dph_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .req      (req),
        .ch       (ch),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .front    (front)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == CLR_LAST) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign cmd.clear    = clearing_reg;
    assign cmd.inc      = s1_hit_reg;
    assign cmd.clr_addr = clr_addr_reg;

    for (genvar lv = 0; lv < PREFIX_LEVELS; lv++) begin : g_bank
        localparam int AW = 2 * lv + 2;
        logic [AW-1:0] rd_addr;
        assign rd_addr = front.hit ? front.word_next[2*TRIGGER_POS-1 -: AW] : query_index[AW-1:0];
        dph_bank #(
            .LEVEL        (lv),
            .COUNTER_BITS (COUNTER_BITS)
        ) u_bank (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .rd_addr (rd_addr),
            .value   (bank_val[lv])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            s1_hit_reg   <= 1'b0;
            s1_query_reg <= 1'b0;
        end else begin
            if (front.hit && total_reg != '1) begin
                total_reg <= total_reg + 1'b1;
            end
            s1_hit_reg   <= front.hit;
            s1_query_reg <= accept && (req == REQ_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        s1_level_reg  <= query_level;
        s1_lvl_ok_reg <= ({1'b0, query_level} < 4'(PREFIX_LEVELS));
        s1_total_reg  <= total_reg;
    end

    always_comb begin
        sel_val = '0;
        for (int lv = 0; lv < PREFIX_LEVELS; lv++) begin
            if (s1_level_reg == 3'(lv)) begin
                sel_val = bank_val[lv];
            end
        end
    end

    assign count_val  = s1_lvl_ok_reg ? sel_val : '0;
    assign limit      = (s1_level_reg == 3'd0) ? (s1_total_reg >> 1) : (s1_total_reg >> 3);
    assign resp.count = 32'(count_val);
    assign resp.above = s1_lvl_ok_reg && (count_val > limit);
    assign resp.total = 32'(s1_total_reg);

    dph_resp_fifo u_resp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_query_reg),
        .push_data (resp),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_resp),
        .count     (fifo_count)
    );

    assign m_tdata = {7'd0, m_resp};

    a_no_hit_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s1_hit_reg && !s1_query_reg)
        else $error("counting or query in flight during clearing pass");

    a_hit_query_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s1_hit_reg && s1_query_reg))
        else $error("increment and query in the same stage");

    a_room_for_query: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_query_reg |-> fifo_count < CW'(RESP_DEPTH))
        else $error("query reached a full result queue");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> total_reg >= $past(total_reg))
        else $error("total count decreased");

    a_hit_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_hit_reg |=> !s1_hit_reg)
        else $error("back-to-back counting events");

endmodule

`default_nettype wire
